// ===== src/slc1d_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the 1-D single-linkage clustering unit.
// No dependencies; used by the cell and the top level.
package slc1d_pkg;

  localparam int LABEL_W = 6;
  localparam int VALUE_W = 32;
  localparam int DIST_W  = 32;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_REDUCE,
    ST_EMIT
  } state_t;

  // Per-cycle commands fanned out to every cell
  typedef struct packed {
    logic wr;
    logic init;
    logic clr;
    logic bvld;
    logic shift;
    logic relabel;
  } cell_ctrl_t;

  // Reference point broadcast during the pair scan
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [LABEL_W-1:0]        label;
    logic [LABEL_W-1:0]        idx;
  } bcast_t;

  // Relabel command for one merge
  typedef struct packed {
    logic [LABEL_W-1:0] la;
    logic [LABEL_W-1:0] lb;
    logic [LABEL_W-1:0] new_label;
  } relab_t;

  // Best pair candidate: lower index, distance and both labels
  typedef struct packed {
    logic               found;
    logic [DIST_W-1:0]  gap;
    logic [LABEL_W-1:0] idx;
    logic [LABEL_W-1:0] la;
    logic [LABEL_W-1:0] lb;
  } cand_t;

endpackage

// ===== src/slc1d_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for points in and merges out.
// Depends on nothing.
interface slc1d_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_value;
  logic               last_point;
  modport source (output valid, point_value, last_point, input ready);
  modport sink   (input valid, point_value, last_point, output ready);
endinterface

interface slc1d_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] first_cluster;
  logic [5:0] second_cluster;
  logic       final_merge;
  modport source (output valid, first_cluster, second_cluster, final_merge, input ready);
  modport sink   (input valid, first_cluster, second_cluster, final_merge, output ready);
endinterface

// ===== src/slc1d_cell.sv =====
`timescale 1ns / 1ps
// One point cell: stores a point and its label, tracks the best pair
// ending at this point, and shifts its candidate toward cell 0.
// Depends on slc1d_pkg.
module slc1d_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 6
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  slc1d_pkg::cell_ctrl_t                   ctrl,
  input  logic [slc1d_pkg::LABEL_W-1:0]           wr_idx,
  input  logic signed [slc1d_pkg::VALUE_W-1:0]    wr_value,
  input  logic [CNT_W-1:0]                        n,
  input  slc1d_pkg::bcast_t                       bcast,
  input  slc1d_pkg::relab_t                       relab,
  input  slc1d_pkg::cand_t                        cand_in,
  output slc1d_pkg::cand_t                        cand,
  output logic signed [slc1d_pkg::VALUE_W-1:0]    value,
  output logic [slc1d_pkg::LABEL_W-1:0]           label
);
  import slc1d_pkg::*;

  localparam logic [LABEL_W-1:0] MY     = LABEL_W'(INDEX);
  localparam logic [CNT_W-1:0]   MY_CNT = CNT_W'(INDEX);

  logic signed [VALUE_W:0] diff;
  logic [VALUE_W:0]        neg;
  logic [DIST_W-1:0]       gap;
  logic                    hit;

  // absolute difference against the broadcast point
  always_comb begin
    diff = {value[VALUE_W-1], value} - {bcast.value[VALUE_W-1], bcast.value};
    neg  = -diff;
    gap  = diff[VALUE_W] ? neg[DIST_W-1:0] : diff[DIST_W-1:0];
    hit  = ctrl.bvld && (bcast.idx < MY) && (MY_CNT < n) && (bcast.label != label) &&
           (!cand.found || gap < cand.gap);
  end

  // point storage
  always_ff @(posedge clk) begin
    if (ctrl.wr && wr_idx == MY) value <= wr_value;
  end

  // label: own index at start, new id when its cluster merges
  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      label <= MY;
    end else if (ctrl.relabel && (label == relab.la || label == relab.lb)) begin
      label <= relab.new_label;
    end
  end

  // best candidate; strict compare keeps the lowest partner index on ties
  always_ff @(posedge clk) begin
    if (rst) begin
      cand <= '0;
    end else if (ctrl.clr) begin
      cand.found <= 1'b0;
    end else if (ctrl.shift) begin
      cand <= cand_in;
    end else if (hit) begin
      cand <= '{found: 1'b1, gap: gap, idx: bcast.idx, la: bcast.label, lb: label};
    end
  end

endmodule

// ===== src/single_linkage_cluster_1d_unit.sv =====
`timescale 1ns / 1ps
// Single-linkage clustering of 1-D Q16.16 points. Points load into a chain
// of cells, one per cycle while the unit is in its load state; after the
// last point, each of the n-1 merges runs a setup step, a scan broadcasting
// each point to all cells (every cell keeps its best pair), a shift of the
// candidates down the chain into the picker, then one output beat, which
// waits while the output stalls. No points are taken until the last merge
// beat of a set is taken.
// Depends on slc1d_pkg, slc1d_if and slc1d_cell.
module single_linkage_cluster_1d_unit #(
  parameter int MAX_POINTS = 32
) (
  input  logic              clk,
  input  logic              rst,
  slc1d_in_if.sink          points,
  slc1d_out_if.source       merges
);
  import slc1d_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

  state_t               state, state_next;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     n;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     merge_cnt;
  logic [LABEL_W-1:0]   next_id;
  logic                 bvld;
  bcast_t               bcast;
  cand_t                acc;
  cell_ctrl_t           ctrl;
  relab_t               relab;
  logic                 in_acc, out_acc, is_final;
  logic [CNT_W-1:0]     n_eff;

  logic signed [VALUE_W-1:0] cell_value [MAX_POINTS];
  logic [LABEL_W-1:0]        cell_label [MAX_POINTS];
  cand_t                     cell_cand  [MAX_POINTS];

  assign in_acc   = points.valid && points.ready;
  assign out_acc  = merges.valid && merges.ready;
  assign n_eff    = (count < MAX_CNT) ? count + CNT_W'(1) : count;
  assign is_final = (merge_cnt == n - CNT_W'(2));

  // cell chain
  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    cand_t nb;
    if (k < MAX_POINTS - 1) begin : g_mid
      assign nb = cell_cand[k+1];
    end else begin : g_end
      assign nb = '0;
    end
    slc1d_cell #(.INDEX(k), .CNT_W(CNT_W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .wr_idx   (LABEL_W'(count)),
      .wr_value (points.point_value),
      .n        (n),
      .bcast    (bcast),
      .relab    (relab),
      .cand_in  (nb),
      .cand     (cell_cand[k]),
      .value    (cell_value[k]),
      .label    (cell_label[k])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:   if (in_acc && points.last_point) begin
                   state_next = (n_eff > CNT_W'(1)) ? ST_SCAN : ST_LOAD;
                 end
      ST_SCAN:   if (cnt == n) state_next = ST_REDUCE;
      ST_REDUCE: if (cnt == n - CNT_W'(1)) state_next = ST_EMIT;
      ST_EMIT:   if (out_acc) state_next = is_final ? ST_LOAD : ST_SCAN;
      default:   state_next = ST_LOAD;
    endcase
  end

  // outputs and cell commands
  always_comb begin
    points.ready          = (state == ST_LOAD);
    merges.valid          = (state == ST_EMIT);
    merges.first_cluster  = acc.la;
    merges.second_cluster = acc.lb;
    merges.final_merge    = is_final;
    ctrl.wr      = in_acc && (count < MAX_CNT);
    ctrl.init    = in_acc && points.last_point;
    ctrl.clr     = (state == ST_SCAN) && (cnt == '0);
    ctrl.bvld    = bvld;
    ctrl.shift   = (state == ST_REDUCE);
    ctrl.relabel = out_acc;
    relab.la        = acc.la;
    relab.lb        = acc.lb;
    relab.new_label = next_id;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      n         <= '0;
      cnt       <= '0;
      merge_cnt <= '0;
      next_id   <= '0;
      bvld      <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_LOAD: begin
          bvld <= 1'b0;
          cnt  <= '0;
          if (ctrl.init) begin
            count     <= '0;
            n         <= n_eff;
            next_id   <= LABEL_W'(n_eff);
            merge_cnt <= '0;
          end else if (ctrl.wr) begin
            count <= count + CNT_W'(1);
          end
        end
        ST_SCAN: begin
          if (cnt == n) begin
            bvld <= 1'b0;
            cnt  <= '0;
          end else begin
            bvld <= 1'b1;
            cnt  <= cnt + CNT_W'(1);
          end
        end
        ST_REDUCE: begin
          cnt <= (cnt == n - CNT_W'(1)) ? '0 : cnt + CNT_W'(1);
        end
        ST_EMIT: begin
          if (out_acc) begin
            next_id   <= next_id + LABEL_W'(1);
            merge_cnt <= merge_cnt + CNT_W'(1);
          end
        end
        default: bvld <= 1'b0;
      endcase
    end
  end

  // broadcast register, loaded from the scanned cell
  always_ff @(posedge clk) begin
    bcast.value <= cell_value[cnt[IDX_W-1:0]];
    bcast.label <= cell_label[cnt[IDX_W-1:0]];
    bcast.idx   <= LABEL_W'(cnt);
  end

  // picker at the chain head: smallest distance, then lowest indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctrl.clr) begin
      acc.found <= 1'b0;
    end else if (ctrl.shift && cell_cand[0].found &&
                 (!acc.found || cell_cand[0].gap < acc.gap ||
                  (cell_cand[0].gap == acc.gap && cell_cand[0].idx < acc.idx))) begin
      acc <= cell_cand[0];
    end
  end

`ifndef ASSERT_OFF
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    merges.valid |-> !points.ready) else $error("merge beat while loading");
  a_found: assert property (@(posedge clk) disable iff (rst)
    merges.valid |-> acc.found) else $error("merge beat without a pair");
  a_distinct: assert property (@(posedge clk) disable iff (rst)
    merges.valid |-> merges.first_cluster != merges.second_cluster)
    else $error("merge of one cluster with itself");
  a_done: assert property (@(posedge clk) disable iff (rst)
    out_acc && merges.final_merge |=> points.ready) else $error("no reload after final");
`endif

endmodule

// ===== verif/single_linkage_cluster_1d_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the 1-D single-linkage clustering unit: directed point sets,
// then random sets; each merge beat checked by the predictor or a typed row.
// Depends on slc1d_pkg, slc1d_if and single_linkage_cluster_1d_unit.
module single_linkage_cluster_1d_unit_tb;
  import slc1d_pkg::*;

  localparam int MAXP       = 32;
  localparam int IDLE_LIMIT = 20000;
  localparam logic signed [31:0] VMIN = 32'sh8000_0000;
  localparam logic signed [31:0] VMAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic [LABEL_W-1:0] first_lbl;
    logic [LABEL_W-1:0] second_lbl;
    logic               fin;
  } merge_t;

  typedef struct {
    logic signed [31:0] value;
    logic               last;
    bit                 typed;
    logic [LABEL_W-1:0] t_first;
    logic [LABEL_W-1:0] t_second;
    logic               t_fin;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  slc1d_in_if  pin();
  slc1d_out_if pout();

  single_linkage_cluster_1d_unit #(.MAX_POINTS(MAXP)) dut (
    .clk    (clk),
    .rst    (rst),
    .points (pin),
    .merges (pout)
  );

  always #5 clk = ~clk;

  // predictor state
  logic signed [31:0] pts [MAXP];
  logic [LABEL_W-1:0] lbl [MAXP];
  int                 npts = 0;
  merge_t             new_merges[$];
  merge_t             merge_q[$];

  int  errors = 0;
  int  idle_cycles = 0;
  int  burst_left = 0;
  int  items_sent = 0;

  // Store a point; on the last point, work out every merge of the set
  task automatic predict_point(logic signed [31:0] v, logic last);
    int n, mcount, bi, bj;
    bit found;
    logic [31:0] bd, d;
    logic signed [32:0] diff;
    logic [LABEL_W-1:0] la, lb, next_id;
    merge_t m;
    new_merges.delete();
    if (npts < MAXP) begin
      pts[npts] = v;
      npts++;
    end
    if (!last) return;
    n = npts;
    for (int i = 0; i < n; i++) lbl[i] = LABEL_W'(i);
    next_id = LABEL_W'(n);
    mcount = 0;
    while (n > 1 && mcount < n - 1) begin
      found = 0; bi = 0; bj = 0; bd = '0;
      for (int i = 0; i < n; i++)
        for (int j = i + 1; j < n; j++) begin
          if (lbl[i] != lbl[j]) begin
            diff = 33'(pts[i]) - 33'(pts[j]);
            if (diff < 0) diff = -diff;
            d = diff[31:0];
            if (!found || d < bd) begin
              found = 1; bd = d; bi = i; bj = j;
            end
          end
        end
      if (!found) break;
      la = lbl[bi];
      lb = lbl[bj];
      m.first_lbl = la;
      m.second_lbl = lb;
      m.fin = (mcount + 1 == n - 1);
      new_merges = {new_merges, m};
      for (int k = 0; k < n; k++)
        if (lbl[k] == la || lbl[k] == lb) lbl[k] = next_id;
      next_id++;
      mcount++;
    end
    npts = 0;
  endtask

  // Drive one point beat, with burst/gap idling on the sender side
  task automatic send_point(logic signed [31:0] v, logic last);
    int gap_len;
    if (burst_left == 0) begin
      gap_len = $urandom_range(0, 6);
      if (gap_len > 0) begin
        pin.valid <= 1'b0;
        repeat (gap_len) @(negedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    pin.valid       <= 1'b1;
    pin.point_value <= v;
    pin.last_point  <= last;
    @(posedge clk);
    while (!pin.ready) @(posedge clk);
    burst_left--;
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_predicted(logic signed [31:0] v, logic last);
    predict_point(v, last);
    foreach (new_merges[i]) merge_q = {merge_q, new_merges[i]};
    send_point(v, last);
  endtask

  // Receiver stall pattern: phases of full rate and phases of random stalls
  int rx_phase = 0;
  int rx_mode = 0;
  always @(negedge clk) begin
    if (rx_phase == 0) begin
      rx_phase <= $urandom_range(5, 60);
      rx_mode  <= $urandom_range(0, 2);
    end else begin
      rx_phase <= rx_phase - 1;
    end
    case (rx_mode)
      0: pout.ready <= 1'b1;
      1: pout.ready <= ($urandom_range(0, 3) != 0);
      default: pout.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Merge beat checker
  always @(posedge clk) begin
    merge_t e;
    if (!rst && pout.valid && pout.ready) begin
      if (merge_q.size() == 0) begin
        $display("%0t: unexpected merge beat %0d %0d %0b", $time,
                 pout.first_cluster, pout.second_cluster, pout.final_merge);
        errors++;
      end else begin
        e = merge_q.pop_front();
        if (pout.first_cluster !== e.first_lbl) begin
          $display("%0t: first_cluster expected %0d actual %0d", $time,
                   e.first_lbl, pout.first_cluster);
          errors++;
        end
        if (pout.second_cluster !== e.second_lbl) begin
          $display("%0t: second_cluster expected %0d actual %0d", $time,
                   e.second_lbl, pout.second_cluster);
          errors++;
        end
        if (pout.final_merge !== e.fin) begin
          $display("%0t: final_merge expected %0b actual %0b", $time,
                   e.fin, pout.final_merge);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (pin.valid && pin.ready) || (pout.valid && pout.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** single_linkage_cluster_1d_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  row_t dir_tab[] = '{
    // extremes: widest possible distance
    '{VMIN, 1'b0, 0, 0, 0, 0},
    '{VMAX, 1'b1, 1, 0, 1, 1},
    // single point: no merge
    '{32'sd5, 1'b1, 0, 0, 0, 0},
    // all distances tie
    '{32'sd0, 1'b0, 0, 0, 0, 0},
    '{32'sd0, 1'b0, 0, 0, 0, 0},
    '{32'sd0, 1'b1, 0, 0, 0, 0},
    // equal points at the top
    '{VMAX, 1'b0, 0, 0, 0, 0},
    '{VMAX, 1'b1, 1, 0, 1, 1},
    '{-32'sd1, 1'b0, 0, 0, 0, 0},
    '{32'sd0, 1'b0, 0, 0, 0, 0},
    '{32'sd1, 1'b0, 0, 0, 0, 0},
    '{32'sd3, 1'b1, 0, 0, 0, 0},
    '{VMIN, 1'b0, 0, 0, 0, 0},
    '{32'sd0, 1'b0, 0, 0, 0, 0},
    '{VMAX, 1'b1, 0, 0, 0, 0},
    '{32'sd100, 1'b0, 0, 0, 0, 0},
    '{32'sd0, 1'b0, 0, 0, 0, 0},
    '{-32'sd100, 1'b0, 0, 0, 0, 0},
    '{32'sd200, 1'b1, 0, 0, 0, 0}
  };

  function automatic logic signed [31:0] rand_value(int mode);
    case (mode)
      0: return $signed($urandom);
      1: return $signed(32'($urandom_range(0, 7)) - 32'd4);
      default: return $signed(32'($urandom_range(0, 65535)) << 8);
    endcase
  endfunction

  initial begin
    merge_t tm;
    int size, mode;
    bit overflow_done;
    pin.valid       = 1'b0;
    pin.point_value = '0;
    pin.last_point  = 1'b0;
    pout.ready      = 1'b0;
    overflow_done   = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    foreach (dir_tab[r]) begin
      predict_point(dir_tab[r].value, dir_tab[r].last);
      if (dir_tab[r].typed) begin
        tm.first_lbl  = dir_tab[r].t_first;
        tm.second_lbl = dir_tab[r].t_second;
        tm.fin        = dir_tab[r].t_fin;
        merge_q = {merge_q, tm};
      end else begin
        foreach (new_merges[i]) merge_q = {merge_q, new_merges[i]};
      end
      send_point(dir_tab[r].value, dir_tab[r].last);
    end

    // hold off until every merge has drained
    pin.valid <= 1'b0;
    while (merge_q.size() != 0) @(negedge clk);

    // random point sets, at times a full store, and one overflowing set
    while (items_sent < 95) begin
      case ($urandom_range(0, 19))
        0: size = MAXP;
        1: size = overflow_done ? 3 : MAXP + 3;
        default: size = $urandom_range(1, 6);
      endcase
      if (size > MAXP) overflow_done = 1;
      mode = $urandom_range(0, 2);
      for (int i = 0; i < size; i++)
        send_predicted(rand_value(mode), i == size - 1);
    end
    if (!overflow_done)
      for (int i = 0; i < MAXP + 2; i++)
        send_predicted(rand_value(0), i == MAXP + 1);

    pin.valid <= 1'b0;
    while (merge_q.size() != 0) @(negedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("** single_linkage_cluster_1d_unit: PASSED **");
    end else begin
      $display("** single_linkage_cluster_1d_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/slc1d_pkg.sv
src/slc1d_if.sv
src/slc1d_cell.sv
src/single_linkage_cluster_1d_unit.sv
verif/single_linkage_cluster_1d_unit_tb.sv
